@@ rtl/core/swst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swst_pkg
// Shared types and codes for the sliding window sender tracker.
// ----------------------------------------------------------------------------
package swst_pkg;

    // Field widths fixed by the interface
    localparam int MODE_W     = 2;
    localparam int SEQ_W      = 32;
    localparam int SLOT_FW    = 10;
    localparam int KIND_W     = 3;
    localparam int WIN_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = WIN_W;

    // Input item modes
    localparam logic [MODE_W-1:0] MODE_ENQ     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACK     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TIMEOUT = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ENQUEUED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REJECTED = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ACK_OK   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ACK_IGN  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RESEND   = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SELECTIVE = 1'd1;

    localparam logic [WIN_W-1:0] WIN_RESET = 7'd8;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SEQ_W-1:0]  ack_seq;
    } t_item;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [SLOT_FW-1:0] slot;
        logic [SEQ_W-1:0]   seq;
        logic               ring_full;
        logic               all_acked;
        logic               restart_timer;
        logic               last;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic slide;
        logic resend;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic go_slide;
        logic go_resend;
        logic slide_more;
        logic pend_last;
    } t_status;

endpackage

@@ rtl/core/sliding_window_sender_tracker.sv @@
`timescale 1ns / 1ps
// Enqueue and plain ack results are registered from the execute state that follows the accepted start.
// Enqueue, cumulative ack, non-base selective ack, empty timeout: a new item is taken only back in idle.
// Selective ack of the base: slides up to MAX_WINDOW (64 by default) entries, one per cycle.
// Timeout: sweeps the window up to the last pending entry, one entry per cycle.
// Synchronous active-low reset clears the window, sets an 8-entry window, cumulative mode.
// Results cannot be stalled: each is valid for exactly one cycle; busy clears with the last.
// ----------------------------------------------------------------------------
// sliding_window_sender_tracker
// Sender-side go-back-N / selective-repeat window tracker, top level.
// ----------------------------------------------------------------------------
module sliding_window_sender_tracker
    import swst_pkg::*;
#(
    parameter int RING_SLOTS = 1024,
    parameter int MAX_WINDOW = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  t_item                 i_item,
    output logic                  busy,
    output logic                  o_res_valid,
    output t_result               o_res,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // Register writes are taken every cycle
    assign o_cfg_ready = 1'b1;

    swst_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    swst_dp #(
        .RING_SLOTS (RING_SLOTS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_status    (status),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

`ifndef SYNTHESIS
    // A result only follows a cycle of work
    a_res_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(busy))
        else $error("result beat without preceding work");

    // A taken item makes the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("item taken but block not busy");

    // The final result coincides with the block going idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last) |-> !busy)
        else $error("busy still set on final result beat");

    // No further result after the final one until a new item
    a_no_trailing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last) |=> !o_res_valid)
        else $error("result beat after final result");
`endif

endmodule

@@ rtl/core/swst_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swst_ctrl
// Sequencer: accept, execute, selective slide and resend sweep.
// ----------------------------------------------------------------------------
module swst_ctrl
    import swst_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SLIDE,
        S_RESEND
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_status.go_slide)       n_state = S_SLIDE;
                else if (i_status.go_resend) n_state = S_RESEND;
                else                         n_state = S_IDLE;
            end
            S_SLIDE: begin
                if (!i_status.slide_more) n_state = S_IDLE;
            end
            S_RESEND: begin
                if (i_status.pend_last) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    // Commands
    assign o_cmd.load   = (r_state == S_IDLE) && start;
    assign o_cmd.exec   = (r_state == S_EXEC);
    assign o_cmd.slide  = (r_state == S_SLIDE);
    assign o_cmd.resend = (r_state == S_RESEND);
    assign busy         = r_busy;

endmodule

@@ rtl/core/swst_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swst_dp
// Window state, config registers, ack/enqueue updates and result register.
// ----------------------------------------------------------------------------
module swst_dp
    import swst_pkg::*;
#(
    parameter int RING_SLOTS = 1024,
    parameter int MAX_WINDOW = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  t_item                 i_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_status               o_status,
    output logic                  o_res_valid,
    output t_result               o_res
);

    localparam int SLOT_W = $clog2(RING_SLOTS);
    localparam int CNT_W  = $clog2(RING_SLOTS + 1);
    localparam int W      = MAX_WINDOW;
    localparam int OFF_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    // Ring slot of the entry at an offset from a base slot
    function automatic logic [SLOT_W-1:0] slot_at(input logic [SLOT_W-1:0] base,
                                                  input logic [SLOT_W:0]   off);
        logic [SLOT_W:0] sum;
        sum = {1'b0, base} + off;
        if (sum >= (SLOT_W+1)'(RING_SLOTS)) sum = sum - (SLOT_W+1)'(RING_SLOTS);
        return sum[SLOT_W-1:0];
    endfunction

    // Configuration
    logic [WIN_W-1:0]  r_win, n_win;
    logic              r_sel, n_sel;
    // Window state
    logic [SEQ_W-1:0]  r_base_seq, n_base_seq;
    logic [SLOT_W-1:0] r_base_slot, n_base_slot;
    logic [CNT_W-1:0]  r_out, n_out;
    logic [W-1:0]      r_acked, n_acked;
    // Working item and sweep state
    logic [MODE_W-1:0] r_mode, n_mode;
    logic [SEQ_W-1:0]  r_ack, n_ack;
    logic [WIN_W-1:0]  r_lim, n_lim;
    logic [W-1:0]      r_pend, n_pend;
    logic [OFF_W-1:0]  r_off, n_off;
    // Result register
    t_result           r_res, n_res;
    logic              r_res_valid, n_res_valid;

    logic [WIN_W-1:0]  eff_win;
    logic [WIN_W-1:0]  lim;
    logic [SEQ_W-1:0]  ack_off;
    logic [W-1:0]      lim_mask;
    logic [W-1:0]      pend0;
    logic              full;

    // Effective window and acceptance span
    assign eff_win  = (r_win == '0) ? WIN_W'(1) :
                      (r_win > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : r_win;
    assign lim      = (SEQ_W'(r_out) < SEQ_W'(eff_win)) ? WIN_W'(r_out) : eff_win;
    assign ack_off  = r_ack - r_base_seq;
    assign lim_mask = ~({W{1'b1}} << lim);
    assign pend0    = lim_mask & ~(r_sel ? r_acked : '0);
    assign full     = (r_out == CNT_W'(RING_SLOTS));

    // Status to the controller
    assign o_status.go_slide   = (r_mode == MODE_ACK) && r_sel && (ack_off == '0)
                                 && (ack_off < SEQ_W'(lim));
    assign o_status.go_resend  = (r_mode == MODE_TIMEOUT) && (pend0 != '0);
    assign o_status.slide_more = (r_lim != '0) && r_acked[0];
    assign o_status.pend_last  = ((r_pend >> 1) == '0);

    always_comb begin
        n_win       = r_win;
        n_sel       = r_sel;
        n_base_seq  = r_base_seq;
        n_base_slot = r_base_slot;
        n_out       = r_out;
        n_acked     = r_acked;
        n_mode      = r_mode;
        n_ack       = r_ack;
        n_lim       = r_lim;
        n_pend      = r_pend;
        n_off       = r_off;
        n_res       = r_res;
        n_res_valid = 1'b0;

        // Register writes
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WINDOW:    n_win = i_cfg_data;
                CFG_SELECTIVE: n_sel = i_cfg_data[0];
                default: ;
            endcase
        end

        // Capture the item
        if (i_cmd.load) begin
            n_mode = i_item.mode;
            n_ack  = i_item.ack_seq;
        end

        // Single-step updates
        if (i_cmd.exec) begin
            n_res               = '0;
            n_res.last          = 1'b1;
            case (r_mode)
                MODE_ENQ: begin
                    n_res_valid = 1'b1;
                    if (full) begin
                        n_res.kind = KIND_REJECTED;
                    end else begin
                        n_res.kind = KIND_ENQUEUED;
                        n_res.slot = SLOT_FW'(slot_at(r_base_slot, (SLOT_W+1)'(r_out)));
                        n_res.seq  = r_base_seq + SEQ_W'(r_out);
                        n_acked    = r_acked & ~(W'(1) << r_out);
                        n_out      = r_out + CNT_W'(1);
                    end
                end
                MODE_ACK: begin
                    if (!r_sel) begin
                        n_res_valid = 1'b1;
                        if ((ack_off != '0) && (ack_off <= SEQ_W'(lim))) begin
                            n_base_seq          = r_ack;
                            n_base_slot         = slot_at(r_base_slot, (SLOT_W+1)'(ack_off));
                            n_out               = r_out - CNT_W'(ack_off);
                            n_acked             = r_acked >> ack_off;
                            n_res.kind          = KIND_ACK_OK;
                            n_res.restart_timer = 1'b1;
                        end else begin
                            n_res.kind = KIND_ACK_IGN;
                        end
                    end else if (ack_off < SEQ_W'(lim)) begin
                        n_acked = r_acked | (W'(1) << ack_off);
                        if (ack_off == '0) begin
                            // base acked: slide in the following cycles
                            n_lim = lim;
                        end else begin
                            n_res_valid = 1'b1;
                            n_res.kind  = KIND_ACK_OK;
                        end
                    end else begin
                        n_res_valid = 1'b1;
                        n_res.kind  = KIND_ACK_IGN;
                    end
                    n_res.slot = SLOT_FW'(n_base_slot);
                    n_res.seq  = n_base_seq;
                end
                MODE_TIMEOUT: begin
                    n_pend = pend0;
                    n_off  = '0;
                end
                default: ;
            endcase
            n_res.ring_full = (n_out == CNT_W'(RING_SLOTS));
            n_res.all_acked = (n_out == '0);
        end

        // Selective slide, one entry a cycle
        if (i_cmd.slide) begin
            if (o_status.slide_more) begin
                n_base_seq  = r_base_seq + SEQ_W'(1);
                n_base_slot = slot_at(r_base_slot, (SLOT_W+1)'(1));
                n_out       = r_out - CNT_W'(1);
                n_acked     = r_acked >> 1;
                n_lim       = r_lim - WIN_W'(1);
            end else begin
                n_res_valid         = 1'b1;
                n_res               = '0;
                n_res.kind          = KIND_ACK_OK;
                n_res.slot          = SLOT_FW'(r_base_slot);
                n_res.seq           = r_base_seq;
                n_res.restart_timer = 1'b1;
                n_res.last          = 1'b1;
                n_res.ring_full     = full;
                n_res.all_acked     = (r_out == '0);
            end
        end

        // Resend sweep, one window entry a cycle
        if (i_cmd.resend) begin
            n_res_valid     = r_pend[0];
            n_res           = '0;
            n_res.kind      = KIND_RESEND;
            n_res.slot      = SLOT_FW'(slot_at(r_base_slot, (SLOT_W+1)'(r_off)));
            n_res.seq       = r_base_seq + SEQ_W'(r_off);
            n_res.last      = o_status.pend_last;
            n_res.ring_full = full;
            n_res.all_acked = (r_out == '0);
            n_pend          = r_pend >> 1;
            n_off           = r_off + OFF_W'(1);
        end
    end

    // Control and window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win       <= WIN_RESET;
            r_sel       <= 1'b0;
            r_base_seq  <= '0;
            r_base_slot <= '0;
            r_out       <= '0;
            r_acked     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_win       <= n_win;
            r_sel       <= n_sel;
            r_base_seq  <= n_base_seq;
            r_base_slot <= n_base_slot;
            r_out       <= n_out;
            r_acked     <= n_acked;
            r_res_valid <= n_res_valid;
        end
    end

    // Payload and sweep registers
    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_ack  <= n_ack;
        r_lim  <= n_lim;
        r_pend <= n_pend;
        r_off  <= n_off;
        r_res  <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule
